FILE: hdl/fbdt_pkg.sv
`default_nettype none
package fbdt_pkg;

  // fixed point one and one half, 256 means 1.0
  localparam logic [9:0] ONE_FIX  = 10'd256;
  localparam logic [9:0] HALF_FIX = 10'd128;

  // write enables toward the pixel stores
  typedef struct packed {
    logic color_we;
    logic depth_we;
  } store_wr_t;

  // saturate a 2.8 channel at one and scale to a byte
  function automatic logic [7:0] to_byte(input logic [9:0] c);
    logic [8:0]  v;
    logic [16:0] p;
    v = (c > ONE_FIX) ? ONE_FIX[8:0] : c[8:0];
    p = {8'b0, v} * 17'd255;
    return p[15:8];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fbdt_store.sv
`default_nettype none
module fbdt_store #(
  parameter int PIXEL_COUNT = 65536,
  parameter int DEPTH_BITS  = 24,
  parameter int AW          = 16
) (
  input  wire                  clk,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output logic [23:0]          rd_color,
  output logic [DEPTH_BITS-1:0] rd_depth,
  input  wire fbdt_pkg::store_wr_t wr,
  input  wire [AW-1:0]         wr_addr,
  input  wire [23:0]           wr_color,
  input  wire [DEPTH_BITS-1:0] wr_depth
);

  logic [23:0]           color_mem [PIXEL_COUNT];
  logic [DEPTH_BITS-1:0] depth_mem [PIXEL_COUNT];
  logic [23:0]           rd_color_r;
  logic [DEPTH_BITS-1:0] rd_depth_r;

  // color store, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.color_we) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_color_r <= color_mem[rd_addr];
    end
  end

  // depth store, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.depth_we) begin
      depth_mem[wr_addr] <= wr_depth;
    end
    if (rd_en) begin
      rd_depth_r <= depth_mem[rd_addr];
    end
  end

  assign rd_color = rd_color_r;
  assign rd_depth = rd_depth_r;

endmodule
`default_nettype wire

FILE: hdl/fbdt_blend.sv
`default_nettype none
module fbdt_blend (
  input  wire [23:0] src,
  input  wire [23:0] dst,
  input  wire [9:0]  alpha,
  output logic [23:0] result
);

  logic [23:0] mixed;

  // per channel: dst*256 + (src-dst)*a, then drop the fraction
  for (genvar i = 0; i < 3; i++) begin : g_chan
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] sum;
    assign diff = $signed({1'b0, src[8*i +: 8]}) - $signed({1'b0, dst[8*i +: 8]});
    assign prod = $signed({{9{diff[8]}}, diff}) * $signed({10'b0, alpha[7:0]});
    assign sum  = $signed({2'b0, dst[8*i +: 8], 8'b0}) + prod;
    assign mixed[8*i +: 8] = sum[15:8];
  end

  // alpha at or above one keeps the source bytes
  assign result = (alpha < fbdt_pkg::ONE_FIX) ? mixed : src;

endmodule
`default_nettype wire

FILE: hdl/fragment_blend_depth_test.sv
`default_nettype none
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    80-bit fragment word
// out_     out  out_tvalid/tready   32-bit result word
//
// a fragment is handled in order: accept issues the store read, then the compute
// step blends, tests depth, writes back and loads the output register
// the rate is set by the read-modify-write interlock: no new fragment is
// taken until the previous one has written back
// after reset a clearing pass writes every pixel address of the stores with
// black and farthest depth; in_tready stays low meanwhile
// a full output register holds the fragment in the compute step until taken
module fragment_blend_depth_test #(
  parameter int PIXEL_COUNT = 65536,
  parameter int DEPTH_BITS  = 24
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // pixel_index, src_red, src_green, src_blue, src_alpha, frag_depth
  input  wire [79:0]  in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // depth_passed, depth_updated, out_red, out_green, out_blue, zero fill
  output logic [31:0] out_tdata
);

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CALC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // fragment held between accept and write back
  logic                  pix_ok_r;
  logic [AW-1:0]         addr_r;
  logic [23:0]           src_r;
  logic [9:0]            alpha_r;
  logic [DEPTH_BITS-1:0] z_r;

  logic        out_valid_r, out_valid_nxt;
  logic [25:0] out_data_r;

  logic                  accept;
  logic                  in_pix_ok;
  logic [15:0]           in_pix;
  logic [23:0]           rd_color;
  logic [DEPTH_BITS-1:0] rd_depth;
  logic [23:0]           dst;
  logic [23:0]           blended;
  logic                  passed;
  logic                  updated;
  logic                  calc_done;
  fbdt_pkg::store_wr_t   wr;
  logic [AW-1:0]         wr_addr;
  logic [23:0]           wr_color;
  logic [DEPTH_BITS-1:0] wr_depth;

  assign in_pix    = in_tdata[15:0];
  assign in_pix_ok = {9'b0, in_pix} < 25'(PIXEL_COUNT);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  fbdt_store #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .DEPTH_BITS  (DEPTH_BITS),
    .AW          (AW)
  ) u_store (
    .clk      (clk),
    .rd_en    (accept && in_pix_ok),
    .rd_addr  (AW'(in_pix)),
    .rd_color (rd_color),
    .rd_depth (rd_depth),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_color (wr_color),
    .wr_depth (wr_depth)
  );

  // out of range pixels blend over black
  assign dst = pix_ok_r ? rd_color : 24'd0;

  fbdt_blend u_blend (
    .src    (src_r),
    .dst    (dst),
    .alpha  (alpha_r),
    .result (blended)
  );

  // depth test and write back decision
  assign passed    = pix_ok_r && (z_r < rd_depth);
  assign updated   = passed && (alpha_r > fbdt_pkg::HALF_FIX);
  assign calc_done = (state_r == S_CALC) && (!out_valid_r || out_tready);

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr.color_we = 1'b1;
      wr.depth_we = 1'b1;
      wr_addr     = clr_cnt_r;
      wr_color    = 24'd0;
      wr_depth    = '1;
    end else begin
      wr.color_we = calc_done && passed;
      wr.depth_we = calc_done && updated;
      wr_addr     = addr_r;
      wr_color    = blended;
      wr_depth    = z_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(PIXEL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (calc_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (calc_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the fragment, colors already turned into bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_ok_r <= in_pix_ok;
      addr_r   <= AW'(in_pix);
      src_r    <= {fbdt_pkg::to_byte(in_tdata[45:36]),
                   fbdt_pkg::to_byte(in_tdata[35:26]),
                   fbdt_pkg::to_byte(in_tdata[25:16])};
      alpha_r  <= in_tdata[55:46];
      z_r      <= DEPTH_BITS'(in_tdata[79:56]);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (calc_done) begin
      out_data_r <= {blended, updated, passed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // depth is never written without the color
  a_depth_with_color: assert property (@(posedge clk) disable iff (!rst_n)
    wr.depth_we |-> wr.color_we)
    else $error("depth write without color write");

  // an accepted fragment goes to the compute step
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CALC)
    else $error("accepted fragment not computed");

  // a new result only comes from the compute step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_CALC))
    else $error("result without computed fragment");

  // a depth update implies a passed test
  a_update_passed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("depth updated without pass");

endmodule
`default_nettype wire
